### rtl/msan_pkg.sv
// Package: shared types and constants of the memory region list sanitizer.
package msan_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CNT_W           = 9;
    localparam int IDX_W           = 8;
    localparam logic [31:0] FREE_TYPE = 32'd1;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] rtype;
    } region_t;

    // One request from the front to the back: an optional closed region,
    // then on the last item the final region (if any).
    typedef struct packed {
        logic    has_a;
        region_t a;
        logic    last;
        logic    has_b;
        region_t b;
    } cmd_t;

    typedef enum logic {
        PH_FIRST = 1'b0,
        PH_FINAL = 1'b1
    } phase_t;

    typedef struct packed {
        logic             entry_valid;
        logic [31:0]      base;
        logic [31:0]      len;
        logic [31:0]      rtype;
        logic [IDX_W-1:0] index;
        logic             eot;
        logic [CNT_W-1:0] count;
        logic [31:0]      top;
        logic             ovf;
    } result_t;

endpackage

### rtl/msan_front.sv
// Front: filters and clamps regions, merges into the pending region, issues requests.
module msan_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         region_base,
    input  logic [63:0]         region_length,
    input  logic [31:0]         region_type,
    input  logic                is_last,
    output logic                q_push,
    output msan_pkg::cmd_t      q_cmd,
    input  logic                q_full
);

    logic                pv_reg, pv_next;
    msan_pkg::region_t   pend_reg, pend_next;

    logic                accept;
    logic                keep;
    logic [31:0]         b32;
    logic [31:0]         len_c;
    logic [32:0]         sum33;
    logic [31:0]         len_k;
    logic [31:0]         pend_end;
    logic                merge;
    msan_pkg::cmd_t      cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        b32      = region_base[31:0];
        keep     = (region_length != 64'd0) && (region_base[63:32] == 32'd0);
        len_c    = (|region_length[63:32]) ? 32'hffff_ffff : region_length[31:0];
        sum33    = {1'b0, b32} + {1'b0, len_c};
        len_k    = sum33[32] ? ~b32 : len_c;
        pend_end = pend_reg.base + pend_reg.len;
        merge    = pv_reg && (region_type == pend_reg.rtype) && (b32 == pend_end);

        pv_next   = pv_reg;
        pend_next = pend_reg;
        cmd       = '0;

        if (keep)
        begin
            if (merge)
            begin
                pend_next.len = pend_reg.len + len_k;
            end
            else
            begin
                cmd.has_a       = pv_reg;
                cmd.a           = pend_reg;
                pend_next.base  = b32;
                pend_next.len   = len_k;
                pend_next.rtype = region_type;
                pv_next         = 1'b1;
            end
        end

        if (is_last)
        begin
            cmd.last  = 1'b1;
            cmd.has_b = pv_next;
            cmd.b     = pend_next;
            pv_next   = 1'b0;
            pend_next = '0;
        end
    end

    assign q_push = accept && (cmd.has_a || cmd.last);
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            pv_reg   <= pv_next;
            pend_reg <= pend_next;
        end
    end

endmodule

### rtl/msan_fifo.sv
// Request queue between front and back.
module msan_fifo #(
    parameter int DEPTH = msan_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  msan_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output msan_pkg::cmd_t  head,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msan_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/msan_back.sv
// Back: numbering, capacity check, largest-free tracking and result register.
module msan_back #(
    parameter int MAX_ENTRIES = msan_pkg::MAX_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  msan_pkg::cmd_t     head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output msan_pkg::result_t  result
);

    localparam logic [msan_pkg::CNT_W-1:0] MAX_CNT = msan_pkg::CNT_W'(MAX_ENTRIES);

    msan_pkg::phase_t               phase_reg, phase_next;
    logic [msan_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           drop_reg, drop_next;
    logic [31:0]                    lsize_reg, lsize_next;
    logic [31:0]                    lend_reg, lend_next;
    logic                           ov_reg, ov_next;
    msan_pkg::result_t              res_reg, res_next;

    logic                           advance;
    logic                           act_a;
    logic                           cap_full;
    logic                           emit;
    logic                           produce;
    msan_pkg::region_t              r;

    assign advance  = !empty && (!ov_reg || out_ready);
    assign act_a    = (phase_reg == msan_pkg::PH_FIRST) && head.has_a;
    assign cap_full = (cnt_reg >= MAX_CNT);
    assign r        = act_a ? head.a : head.b;
    assign emit     = (act_a || head.has_b) && !cap_full;
    assign produce  = act_a ? emit : 1'b1;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        lsize_next = lsize_reg;
        lend_next  = lend_reg;

        if (emit && (r.rtype == msan_pkg::FREE_TYPE) && (r.len > lsize_reg))
        begin
            lsize_next = r.len;
            lend_next  = r.base + r.len - 32'd1;
        end
        if (emit)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (act_a || head.has_b)
        begin
            drop_next = 1'b1;
        end

        if (act_a)
        begin
            if (head.last)
            begin
                phase_next = msan_pkg::PH_FINAL;
            end
        end
        else
        begin
            phase_next = msan_pkg::PH_FIRST;
        end
    end

    // queue pop: a last request with a closed region stays for its final half
    always_comb
    begin
        pop = 1'b0;
        if (!act_a || !head.last)
        begin
            pop = advance;
        end
    end

    // result
    always_comb
    begin
        res_next = '0;
        if (emit)
        begin
            res_next.entry_valid = 1'b1;
            res_next.base        = r.base;
            res_next.len         = r.len;
            res_next.rtype       = r.rtype;
            res_next.index       = cnt_reg[msan_pkg::IDX_W-1:0];
        end
        if (!act_a)
        begin
            res_next.eot   = 1'b1;
            res_next.count = cnt_next;
            res_next.top   = lend_next;
            res_next.ovf   = drop_next;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (advance && produce)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= msan_pkg::PH_FIRST;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            lsize_reg <= '0;
            lend_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                if (act_a)
                begin
                    cnt_reg   <= cnt_next;
                    drop_reg  <= drop_next;
                    lsize_reg <= lsize_next;
                    lend_reg  <= lend_next;
                end
                else
                begin
                    cnt_reg   <= '0;
                    drop_reg  <= 1'b0;
                    lsize_reg <= '0;
                    lend_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = ov_reg;
    assign result    = res_reg;

endmodule

### rtl/memory_region_list_sanitizer_unit.sv
// Top level of the memory region list sanitizer.
//
// Input stream (s_axis): one memory-map region per request; tdata carries
// base, length and type, tlast marks the last region of the table.
// Output stream (m_axis): cleaned regions; tuser is entry_valid, tlast is
// end_of_table. A region is held pending until a following region shows
// it cannot merge, or until the last region of the table arrives.
// Throughput: one region per cycle while the request queue is not full. A last
// region that also closes an earlier pending region gives two results and
// holds the back end for both of them; the request queue absorbs this.
// The request that closes a region goes from the front into the queue, and
// the back end moves its result into the output register.
// Reset clears the pending region, counters and queue; the block accepts
// regions as soon as reset is released.
// When m_axis_tready is low the output register holds its result; the
// front keeps accepting until the queue fills, then drops s_axis_tready.
module memory_region_list_sanitizer_unit #(
    parameter int MAX_ENTRIES = msan_pkg::MAX_ENTRIES_DEF,
    parameter int QUEUE_DEPTH = msan_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // [63:0] region_base, [127:64] region_length, [159:128] region_type
    input  logic [159:0]    s_axis_tdata,
    input  logic            s_axis_tlast,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // [31:0] out_base, [63:32] out_length, [95:64] out_type,
    // [103:96] entry_index, [112:104] kept_count, [144:113] largest_free_top,
    // [145] overflow, [151:146] zero
    output logic [151:0]    m_axis_tdata,
    // [0] entry_valid
    output logic            m_axis_tuser,
    output logic            m_axis_tlast
);

    logic               q_push, q_full, q_pop, q_empty;
    msan_pkg::cmd_t     q_cmd, q_head;
    msan_pkg::result_t  res;

    msan_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .region_base   (s_axis_tdata[63:0]),
        .region_length (s_axis_tdata[127:64]),
        .region_type   (s_axis_tdata[159:128]),
        .is_last       (s_axis_tlast),
        .q_push        (q_push),
        .q_cmd         (q_cmd),
        .q_full        (q_full)
    );

    msan_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    msan_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (res)
    );

    assign m_axis_tdata = {6'd0, res.ovf, res.top, res.count, res.index,
                           res.rtype, res.len, res.base};
    assign m_axis_tuser = res.entry_valid;
    assign m_axis_tlast = res.eot;

endmodule

### rtl/msan_checker.sv
// Checker on the sanitizer ports, bound to the top level.
module msan_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  logic [151:0]    m_axis_tdata,
    input  logic            m_axis_tuser,
    input  logic            m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result before end of table");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[103:0] == 104'd0)
        else $error("end marker carries region fields");

    a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[145:104] == 42'd0)
        else $error("summary fields set before end of table");

    a_final_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser
        |-> m_axis_tdata[112:104] == {1'b0, m_axis_tdata[103:96]} + 9'd1)
        else $error("kept count does not follow last index");

endmodule

bind memory_region_list_sanitizer_unit msan_checker u_msan_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/memory_region_list_sanitizer_unit_tb.sv
// Testbench for memory_region_list_sanitizer_unit: directed and random region tables.
module memory_region_list_sanitizer_unit_tb;

    localparam int          CAPACITY    = msan_pkg::MAX_ENTRIES_DEF;
    localparam logic [63:0] LOW4G_MAX   = 64'h0000_0000_ffff_ffff;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD   = 400;
    localparam int          TAIL_CYCLES = 8;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [159:0]   s_axis_tdata;
    logic           s_axis_tlast;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [151:0]   m_axis_tdata;
    logic           m_axis_tuser;
    logic           m_axis_tlast;

    // open (pending) region and per-table bookkeeping of the cleaner
    logic [31:0]    open_base;
    logic [31:0]    open_len;
    logic [31:0]    open_type;
    logic           open_vld;
    logic [31:0]    free_best_size;
    logic [31:0]    free_best_top;
    logic [8:0]     kept_cnt;
    logic           drop_seen;
    msan_pkg::result_t cleaned_q[$];

    int             err_cnt;
    int             cycle_cnt;
    int             region_cnt;
    bit             src_idle;
    bit             sink_idle;
    int             hold_req;
    int             hold_ack;
    int             hold_left;
    int             sink_gap;

    memory_region_list_sanitizer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void clear_table();
        open_base      = '0;
        open_len       = '0;
        open_type      = '0;
        open_vld       = 1'b0;
        free_best_size = '0;
        free_best_top  = '0;
        kept_cnt       = '0;
        drop_seen      = 1'b0;
    endfunction

    function automatic bit emit_open(input bit fin);
        msan_pkg::result_t r;
        if (kept_cnt >= CAPACITY)
        begin
            drop_seen = 1'b1;
            return 1'b0;
        end
        if (open_type == msan_pkg::FREE_TYPE && open_len > free_best_size)
        begin
            free_best_size = open_len;
            free_best_top  = open_base + open_len - 32'd1;
        end
        r             = '0;
        r.entry_valid = 1'b1;
        r.base        = open_base;
        r.len         = open_len;
        r.rtype       = open_type;
        r.index       = kept_cnt[msan_pkg::IDX_W-1:0];
        kept_cnt      = kept_cnt + 9'd1;
        if (fin)
        begin
            r.eot   = 1'b1;
            r.count = kept_cnt;
            r.top   = free_best_top;
            r.ovf   = drop_seen;
        end
        cleaned_q.push_back(r);
        return 1'b1;
    endfunction

    function automatic void clean_region(input logic [63:0] b, input logic [63:0] l,
                                         input logic [31:0] t, input bit last);
        logic [63:0]       cut;
        bit                got;
        msan_pkg::result_t r;
        if (l != 64'd0 && b <= LOW4G_MAX)
        begin
            cut = (l > LOW4G_MAX) ? LOW4G_MAX : l;
            if (b + cut > LOW4G_MAX)
                cut = LOW4G_MAX - b;
            if (open_vld && t == open_type && b[31:0] == open_base + open_len)
                open_len = open_len + cut[31:0];
            else
            begin
                if (open_vld)
                    void'(emit_open(1'b0));
                open_base = b[31:0];
                open_len  = cut[31:0];
                open_type = t;
                open_vld  = 1'b1;
            end
        end
        if (last)
        begin
            got = open_vld ? emit_open(1'b1) : 1'b0;
            if (!got)
            begin
                // end marker
                r       = '0;
                r.eot   = 1'b1;
                r.count = kept_cnt;
                r.top   = free_best_top;
                r.ovf   = drop_seen;
                cleaned_q.push_back(r);
            end
            clear_table();
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        msan_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cleaned_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: tuser %b tlast %b tdata %h",
                             m_axis_tuser, m_axis_tlast, m_axis_tdata);
            end
            else
            begin
                want = cleaned_q.pop_front();
                check_field("entry_valid", want.entry_valid, m_axis_tuser);
                check_field("out_base", want.base, m_axis_tdata[31:0]);
                check_field("out_length", want.len, m_axis_tdata[63:32]);
                check_field("out_type", want.rtype, m_axis_tdata[95:64]);
                check_field("entry_index", want.index, m_axis_tdata[103:96]);
                check_field("end_of_table", want.eot, m_axis_tlast);
                check_field("kept_count", want.count, m_axis_tdata[112:104]);
                check_field("largest_free_top", want.top, m_axis_tdata[144:113]);
                check_field("overflow", want.ovf, m_axis_tdata[145]);
                check_field("pad", 64'd0, m_axis_tdata[151:146]);
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack      <= hold_req;
            hold_left     <= LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gap != 0)
        begin
            sink_gap      <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 5) == 0)
        begin
            sink_gap      <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("[memory_region_list_sanitizer_unit] ERROR");
            $finish;
        end
    end

    task automatic send_region(input logic [63:0] b, input logic [63:0] l,
                               input logic [31:0] t, input bit last);
        int gap;
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, l, b};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        clean_region(b, l, t, last);
        region_cnt++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (cleaned_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly contiguous runs of few types, with dropped and clamped noise
    task automatic send_table(input int n);
        logic [63:0] b;
        logic [63:0] l;
        logic [63:0] cursor;
        logic [31:0] t;
        logic [31:0] prev_t;
        int          pick;
        cursor = {32'd0, $urandom()};
        prev_t = msan_pkg::FREE_TYPE;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            l    = 64'($urandom_range(1, 32'h000f_ffff));
            if (pick < 50)
                b = cursor;
            else if (pick < 75)
                b = {32'd0, $urandom()};
            else if (pick < 82)
                b = {$urandom(), $urandom()};
            else if (pick < 86)
            begin
                b = cursor;
                l = 64'd0;
            end
            else if (pick < 88)
            begin
                b = cursor;
                l = {$urandom(), 32'd0};
            end
            else if (pick < 94)
            begin
                b = {32'd0, $urandom()};
                l = {$urandom(), $urandom()};
            end
            else
                b = LOW4G_MAX - 64'($urandom_range(0, 64));
            if ($urandom_range(0, 19) == 0)
                t = $urandom();
            else if ($urandom_range(0, 9) < 6)
                t = prev_t;
            else
                t = $urandom_range(0, 3);
            send_region(b, l, t, i == n - 1);
            prev_t = t;
            cursor = {32'd0, b[31:0] + l[31:0]};
        end
    endtask

    task automatic test_dropped_regions();
        send_region(64'h1000, 64'd0, msan_pkg::FREE_TYPE, 1'b0);
        send_region(64'h1_0000_0000, 64'h1000, msan_pkg::FREE_TYPE, 1'b0);
        send_region('1, '1, '1, 1'b0);
        send_region(64'h8000_0000_0000_0000, 64'd0, 32'd0, 1'b1);
        drain_results();
    endtask

    task automatic test_clamping_and_merge();
        send_region(64'd0, '1, msan_pkg::FREE_TYPE, 1'b0);
        send_region(LOW4G_MAX, 64'h10, msan_pkg::FREE_TYPE, 1'b0);
        send_region(LOW4G_MAX, 64'd5, 32'd2, 1'b0);
        send_region(LOW4G_MAX, 64'd1, 32'd2, 1'b0);
        // low 32 bits of length zero, upper bits set
        send_region(64'h2000, 64'h1_0000_0000, 32'd2, 1'b0);
        send_region(64'h10, 64'h10, '1, 1'b1);
        drain_results();
    endtask

    task automatic test_largest_free();
        send_region(64'h100, 64'h100, msan_pkg::FREE_TYPE, 1'b0);
        send_region(64'h300, 64'h100, msan_pkg::FREE_TYPE, 1'b0);
        send_region(64'h1000, 64'h800, 32'd0, 1'b0);
        send_region(64'h1800, 64'h10, 32'd3, 1'b0);
        send_region(64'h4000, 64'h200, msan_pkg::FREE_TYPE, 1'b0);
        send_region(64'h4200, 64'h100, msan_pkg::FREE_TYPE, 1'b0);
        send_region(64'h2_0000_0000, 64'd1, msan_pkg::FREE_TYPE, 1'b1);
        drain_results();
    endtask

    task automatic test_last_region();
        send_region(64'h0, 64'h10, 32'd4, 1'b0);
        send_region(64'h10, 64'h20, 32'd4, 1'b1);
        send_region(64'h500, 64'h1, msan_pkg::FREE_TYPE, 1'b1);
        drain_results();
    endtask

    task automatic test_capacity();
        logic [63:0] b;
        logic [63:0] l;
        logic [31:0] t;
        for (int i = 0; i < CAPACITY + 4; i++)
        begin
            b = 64'(i) << 12;
            l = (i < CAPACITY) ? 64'($urandom_range(1, 12'h800)) : 64'hfff;
            t = (i % 3 == 0 || i >= CAPACITY) ? msan_pkg::FREE_TYPE
                                              : 32'($urandom_range(2, 5));
            send_region(b, l, t, i == CAPACITY + 3);
        end
        drain_results();
    endtask

    task automatic test_random_tables();
        int goal;
        goal = region_cnt + 360;
        while (region_cnt < goal)
        begin
            src_idle  = $urandom_range(0, 2) != 0;
            sink_idle = $urandom_range(0, 2) != 0;
            send_table($urandom_range(1, 24));
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        int goal;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        hold_req++;
        goal = region_cnt + 60;
        while (region_cnt < goal)
            send_table($urandom_range(4, 16));
        drain_results();
    endtask

    task automatic test_full_rate();
        int goal;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        goal = region_cnt + 120;
        while (region_cnt < goal)
            send_table($urandom_range(1, 24));
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        clear_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_dropped_regions();
        test_clamping_and_merge();
        test_largest_free();
        test_last_region();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        test_capacity();
        test_random_tables();
        test_backpressure();
        test_full_rate();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("[memory_region_list_sanitizer_unit] OK");
        else
            $display("[memory_region_list_sanitizer_unit] ERROR");
        $finish;
    end

endmodule
